>>> hdl/tlbflt_pkg.sv
// ----------------------------------------------------------------------------
// tlbflt_pkg
// Shared types and constants of the FIFO/LRU translation buffer.
// ----------------------------------------------------------------------------
package tlbflt_pkg;

  localparam int TLB_DEPTH_DEFAULT = 16;

  // request codes
  localparam logic [1:0] REQ_TRANSLATE = 2'd0;
  localparam logic [1:0] REQ_FILL      = 2'd1;
  localparam logic [1:0] REQ_FLUSH     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PAGE_SIZE   = 2'd0;
  localparam logic [1:0] CFG_ENTRIES_TBL = 2'd1;
  localparam logic [1:0] CFG_TLB_ENTRIES = 2'd2;
  localparam logic [1:0] CFG_REPLACE_LRU = 2'd3;

  localparam logic [16:0] PAGE_SIZE_RST   = 17'd64;
  localparam logic [10:0] ENTRIES_TBL_RST = 11'd4;
  localparam logic [4:0]  TLB_ENTRIES_RST = 5'd4;

  typedef enum logic [1:0] {
    WR_SHIFT,   // slot idx - gap <= read data
    WR_TAIL,    // slot count - 1 <= hit entry
    WR_APPEND   // slot count <= fill pair
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    div_save1;
    logic    div_save2;
    logic    idx_inc;
    logic    hit_set;
    logic    rd_en;
    logic    rd_zero;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    evict_start;
    logic    evict_cap;
    logic    fill_trim;
    logic    count_inc;
    logic    mul_en;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       lru;
    logic       div_last;
    logic       idx_end;
    logic       match;
    logic       full;
  } sts_t;

endpackage

>>> hdl/tlbflt_ctrl.sv
// ----------------------------------------------------------------------------
// tlbflt_ctrl
// Sequencer: divisions, list search, LRU reorder, fill and eviction.
// ----------------------------------------------------------------------------
module tlbflt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tlbflt_pkg::sts_t  sts_i,
  output tlbflt_pkg::cmd_t  cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import tlbflt_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV1  = 4'd1;
  localparam logic [3:0] ST_DIV2  = 4'd2;
  localparam logic [3:0] ST_S_RD  = 4'd3;
  localparam logic [3:0] ST_S_CMP = 4'd4;
  localparam logic [3:0] ST_L_RD  = 4'd5;
  localparam logic [3:0] ST_L_WR  = 4'd6;
  localparam logic [3:0] ST_L_FIN = 4'd7;
  localparam logic [3:0] ST_MUL   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;
  localparam logic [3:0] ST_F_CHK = 4'd10;
  localparam logic [3:0] ST_F_EV  = 4'd11;
  localparam logic [3:0] ST_F_RD  = 4'd12;
  localparam logic [3:0] ST_F_WR  = 4'd13;
  localparam logic [3:0] ST_F_APP = 4'd14;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    cmd_o.wr_sel = WR_SHIFT;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (sts_i.req)
            REQ_TRANSLATE: state_d = ST_DIV1;
            REQ_FILL:      state_d = ST_F_CHK;
            default:       state_d = ST_DONE;
          endcase
        end
      end
      ST_DIV1: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.div_save1 = 1'b1;
          state_d = ST_DIV2;
        end
      end
      ST_DIV2: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.div_save2 = 1'b1;
          state_d = ST_S_RD;
        end
      end
      ST_S_RD: begin
        if (sts_i.idx_end) begin
          state_d = ST_MUL;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = ST_S_CMP;
        end
      end
      ST_S_CMP: begin
        cmd_o.idx_inc = 1'b1;
        if (sts_i.match) begin
          cmd_o.hit_set = 1'b1;
          state_d = sts_i.lru ? ST_L_RD : ST_MUL;
        end else begin
          state_d = ST_S_RD;
        end
      end
      ST_L_RD: begin
        if (sts_i.idx_end) begin
          state_d = ST_L_FIN;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = ST_L_WR;
        end
      end
      ST_L_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d = ST_L_RD;
      end
      ST_L_FIN: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_TAIL;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      ST_F_CHK: begin
        if (sts_i.full) begin
          cmd_o.rd_en       = 1'b1;
          cmd_o.rd_zero     = 1'b1;
          cmd_o.evict_start = 1'b1;
          state_d = ST_F_EV;
        end else begin
          state_d = ST_F_APP;
        end
      end
      ST_F_EV: begin
        cmd_o.evict_cap = 1'b1;
        state_d = ST_F_RD;
      end
      ST_F_RD: begin
        if (sts_i.idx_end) begin
          cmd_o.fill_trim = 1'b1;
          state_d = ST_F_APP;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = ST_F_WR;
        end
      end
      ST_F_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d = ST_F_RD;
      end
      ST_F_APP: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = WR_APPEND;
        cmd_o.count_inc = 1'b1;
        state_d = ST_DONE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

>>> hdl/tlbflt_dp.sv
// ----------------------------------------------------------------------------
// tlbflt_dp
// Datapath: config registers, shared restoring divider, entry memory,
// list pointers and result registers.
// ----------------------------------------------------------------------------
module tlbflt_dp #(
  parameter int TLB_DEPTH = tlbflt_pkg::TLB_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [16:0]       cfg_data_i,
  input  logic [1:0]        req_type_i,
  input  logic [31:0]       logical_address_i,
  input  logic [31:0]       fill_page_i,
  input  logic [15:0]       fill_frame_i,
  input  tlbflt_pkg::cmd_t  cmd_i,
  output tlbflt_pkg::sts_t  sts_o,
  output logic              hit_o,
  output logic [15:0]       frame_out_o,
  output logic [31:0]       physical_address_o,
  output logic [31:0]       page_number_o,
  output logic [31:0]       first_level_index_o,
  output logic [9:0]        second_level_index_o,
  output logic [15:0]       page_offset_o,
  output logic              evicted_o,
  output logic [31:0]       evicted_page_o
);
  import tlbflt_pkg::*;

  localparam int IW = $clog2(TLB_DEPTH + 1);
  localparam int AW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;

  // configuration
  logic [16:0] page_size_q;
  logic [10:0] ept_q;
  logic [4:0]  tlb_entries_q;
  logic        lru_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_size_q   <= PAGE_SIZE_RST;
      ept_q         <= ENTRIES_TBL_RST;
      tlb_entries_q <= TLB_ENTRIES_RST;
      lru_q         <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PAGE_SIZE:   page_size_q   <= cfg_data_i;
        CFG_ENTRIES_TBL: ept_q         <= cfg_data_i[10:0];
        CFG_TLB_ENTRIES: tlb_entries_q <= cfg_data_i[4:0];
        CFG_REPLACE_LRU: lru_q         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [16:0] ps_eff;
  logic [16:0] ept_eff;
  logic [6:0]  tlb_ext;
  logic [6:0]  cap7;
  logic [IW-1:0] cap;

  always_comb begin
    if (page_size_q == 17'd0)          ps_eff = 17'd1;
    else if (page_size_q > 17'd65536)  ps_eff = 17'd65536;
    else                               ps_eff = page_size_q;
    if (ept_q == 11'd0)                ept_eff = 17'd1;
    else if (ept_q > 11'd1024)         ept_eff = 17'd1024;
    else                               ept_eff = {6'd0, ept_q};
    tlb_ext = {2'd0, tlb_entries_q};
    if (tlb_ext == 7'd0)                    cap7 = 7'd1;
    else if (tlb_ext > 7'(TLB_DEPTH))       cap7 = 7'(TLB_DEPTH);
    else                                    cap7 = tlb_ext;
  end
  assign cap = cap7[IW-1:0];

  // request latch
  logic [1:0]  req_q;
  logic [31:0] fpage_q;
  logic [15:0] fframe_q;

  // restoring divider, one quotient bit a cycle
  logic [31:0] dq_q;
  logic [16:0] rem_q;
  logic [16:0] dvs_q;
  logic [4:0]  dcnt_q;
  logic [17:0] dsh;
  logic        dge;
  logic [16:0] rem_nx;
  logic [31:0] dq_nx;

  always_comb begin
    dsh    = {rem_q, dq_q[31]};
    dge    = (dsh >= {1'b0, dvs_q});
    rem_nx = dge ? 17'(dsh - {1'b0, dvs_q}) : dsh[16:0];
    dq_nx  = {dq_q[30:0], dge};
  end

  // list state
  logic [IW-1:0] count_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] gap_q;

  // entry memory
  logic [31:0] mem_page  [TLB_DEPTH];
  logic [15:0] mem_frame [TLB_DEPTH];
  logic [31:0] rd_page_q;
  logic [15:0] rd_frame_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_page;
  logic [15:0]   wr_frame;
  logic [IW-1:0] wr_ptr;

  // results
  logic        hit_q;
  logic [15:0] frame_q;
  logic [31:0] phys_q;
  logic [31:0] page_q;
  logic [31:0] fli_q;
  logic [9:0]  sli_q;
  logic [15:0] off_q;
  logic        evicted_q;
  logic [31:0] evpage_q;

  assign rd_addr = cmd_i.rd_zero ? '0 : idx_q[AW-1:0];

  always_comb begin
    case (cmd_i.wr_sel)
      WR_TAIL: begin
        wr_ptr   = IW'(count_q - 1'b1);
        wr_page  = page_q;
        wr_frame = frame_q;
      end
      WR_APPEND: begin
        wr_ptr   = count_q;
        wr_page  = fpage_q;
        wr_frame = fframe_q;
      end
      default: begin
        wr_ptr   = IW'(idx_q - gap_q);
        wr_page  = rd_page_q;
        wr_frame = rd_frame_q;
      end
    endcase
  end
  assign wr_addr = wr_ptr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_page[wr_addr]  <= wr_page;
      mem_frame[wr_addr] <= wr_frame;
    end
    if (cmd_i.rd_en) begin
      rd_page_q  <= mem_page[rd_addr];
      rd_frame_q <= mem_frame[rd_addr];
    end
  end

  logic [32:0] prod;
  assign prod = 33'(frame_q) * 33'(ps_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      gap_q   <= '0;
      req_q   <= REQ_TRANSLATE;
    end else begin
      if (cmd_i.load) begin
        req_q <= req_type_i;
        if (req_type_i == REQ_FLUSH) count_q <= '0;
      end
      if (cmd_i.div_save2) idx_q <= '0;
      if (cmd_i.idx_inc)   idx_q <= IW'(idx_q + 1'b1);
      if (cmd_i.hit_set)   gap_q <= IW'(1);
      if (cmd_i.evict_start) begin
        gap_q <= IW'(count_q - cap + 1'b1);
        idx_q <= IW'(count_q - cap + 1'b1);
      end
      if (cmd_i.fill_trim) count_q <= IW'(count_q - gap_q);
      if (cmd_i.count_inc) count_q <= IW'(count_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fpage_q   <= fill_page_i;
      fframe_q  <= fill_frame_i;
      dq_q      <= logical_address_i;
      rem_q     <= '0;
      dvs_q     <= ps_eff;
      dcnt_q    <= 5'd31;
      hit_q     <= 1'b0;
      frame_q   <= '0;
      phys_q    <= '0;
      page_q    <= '0;
      fli_q     <= '0;
      sli_q     <= '0;
      off_q     <= '0;
      evicted_q <= 1'b0;
      evpage_q  <= '0;
    end
    // last step of the first division reloads the divider for the second
    if (cmd_i.div_save1) begin
      page_q <= dq_nx;
      off_q  <= rem_nx[15:0];
      dq_q   <= dq_nx;
      rem_q  <= '0;
      dvs_q  <= ept_eff;
      dcnt_q <= 5'd31;
    end else if (cmd_i.div_step) begin
      dq_q   <= dq_nx;
      rem_q  <= rem_nx;
      dcnt_q <= 5'(dcnt_q - 1'b1);
    end
    if (cmd_i.div_save2) begin
      fli_q <= dq_nx;
      sli_q <= rem_nx[9:0];
    end
    if (cmd_i.hit_set) begin
      hit_q   <= 1'b1;
      frame_q <= rd_frame_q;
    end
    if (cmd_i.mul_en) begin
      phys_q <= hit_q ? (prod[31:0] + 32'(off_q)) : 32'd0;
    end
    if (cmd_i.evict_start) evicted_q <= 1'b1;
    if (cmd_i.evict_cap)   evpage_q  <= rd_page_q;
  end

  always_comb begin
    sts_o          = '0;
    sts_o.req      = cmd_i.load ? req_type_i : req_q;
    sts_o.lru      = lru_q;
    sts_o.div_last = (dcnt_q == 5'd0);
    sts_o.idx_end  = (idx_q >= count_q);
    sts_o.match    = (rd_page_q == page_q);
    sts_o.full     = (count_q >= cap);
  end

  assign hit_o                = hit_q;
  assign frame_out_o          = frame_q;
  assign physical_address_o   = phys_q;
  assign page_number_o        = page_q;
  assign first_level_index_o  = fli_q;
  assign second_level_index_o = sli_q;
  assign page_offset_o        = off_q;
  assign evicted_o            = evicted_q;
  assign evicted_page_o       = evpage_q;

endmodule

>>> hdl/tlb_fifo_lru_translate.sv
// ----------------------------------------------------------------------------
// tlb_fifo_lru_translate
// Fully associative TLB kept as an ordered list, FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// The next request is taken in the cycle after the result strobe. A translate
// runs two 32-step divisions and then walks the list; with LRU a hit also moves
// its entry to the tail. A fill into a full buffer drops the head entries and
// shifts the rest down before it appends. Flush clears the count. No stall.
// Reset clears the entry count and loads the config defaults; no clearing pass.
module tlb_fifo_lru_translate #(
  parameter int TLB_DEPTH = tlbflt_pkg::TLB_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] logical_address_i,
  input  logic [31:0] fill_page_i,
  input  logic [15:0] fill_frame_i,
  output logic        result_valid_o,
  output logic        hit_o,
  output logic [15:0] frame_out_o,
  output logic [31:0] physical_address_o,
  output logic [31:0] page_number_o,
  output logic [31:0] first_level_index_o,
  output logic [9:0]  second_level_index_o,
  output logic [15:0] page_offset_o,
  output logic        evicted_o,
  output logic [31:0] evicted_page_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  import tlbflt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tlbflt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (result_valid_o)
  );

  tlbflt_dp #(.TLB_DEPTH(TLB_DEPTH)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_valid_i & cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .req_type_i          (req_type_i),
    .logical_address_i   (logical_address_i),
    .fill_page_i         (fill_page_i),
    .fill_frame_i        (fill_frame_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .hit_o               (hit_o),
    .frame_out_o         (frame_out_o),
    .physical_address_o  (physical_address_o),
    .page_number_o       (page_number_o),
    .first_level_index_o (first_level_index_o),
    .second_level_index_o(second_level_index_o),
    .page_offset_o       (page_offset_o),
    .evicted_o           (evicted_o),
    .evicted_page_o      (evicted_page_o)
  );

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request not taken");

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside request");

  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result repeated");

  a_miss_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !hit_o |-> frame_out_o == 16'd0 && physical_address_o == 32'd0)
    else $error("miss carries a frame");

endmodule

>>> dv/tlb_fifo_lru_translate_tb.sv
// ----------------------------------------------------------------------------
// tlb_fifo_lru_translate_tb
// Drives translate, fill, flush and undefined requests into the TLB under
// several register settings, predicts every result from a local copy of the
// entry list and compares each result strobe field by field.
// ----------------------------------------------------------------------------
module tlb_fifo_lru_translate_tb;
  import tlbflt_pkg::*;

  localparam int          DEPTH     = 16;
  localparam int          CYC_LIMIT = 2000000;
  localparam logic [1:0]  REQ_UNDEF = 2'd3;

  typedef struct packed {
    logic        hit;
    logic [15:0] frame;
    logic [31:0] phys;
    logic [31:0] page;
    logic [31:0] l1_idx;
    logic [9:0]  l2_idx;
    logic [15:0] offset;
    logic        evicted;
    logic [31:0] evicted_page;
  } xlate_res_t;

  logic        clk_i, rst_ni;
  logic        start, busy;
  logic [1:0]  req_type_i;
  logic [31:0] logical_address_i, fill_page_i;
  logic [15:0] fill_frame_i;
  logic        result_valid_o, hit_o, evicted_o;
  logic [15:0] frame_out_o, page_offset_o;
  logic [31:0] physical_address_o, page_number_o, first_level_index_o, evicted_page_o;
  logic [9:0]  second_level_index_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [16:0] cfg_data_i;

  tlb_fifo_lru_translate dut (.*);

  // local copy of the TLB and its registers
  logic [16:0] page_size;
  logic [10:0] ent_per_tbl;
  logic [4:0]  tlb_cap;
  logic        lru_mode;
  logic [31:0] tlb_page [DEPTH];
  logic [15:0] tlb_frame[DEPTH];
  int          tlb_count;

  xlate_res_t  pending_res[$];
  int          err_cnt;
  int          cyc_cnt;
  bit          no_gaps;
  logic [31:0] page_pool[24];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYC_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string fld, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at cycle %0d", fld, got, exp, cyc_cnt);
    err_cnt++;
  endtask

  function automatic xlate_res_t predict_tlb(input logic [1:0] req, input logic [31:0] addr,
                                             input logic [31:0] fpage,
                                             input logic [15:0] fframe);
    xlate_res_t  r;
    logic [31:0] ps, ept, pg, off, cap;
    logic [15:0] fr;
    int          n;
    r = '0;
    if (req == REQ_TRANSLATE) begin
      ps  = (page_size == 0) ? 32'd1 : (page_size > 17'd65536) ? 32'd65536 : 32'(page_size);
      ept = (ent_per_tbl == 0) ? 32'd1 : (ent_per_tbl > 11'd1024) ? 32'd1024 : 32'(ent_per_tbl);
      pg  = addr / ps;
      off = addr % ps;
      r.page   = pg;
      r.l1_idx = pg / ept;
      r.l2_idx = 10'(pg % ept);
      r.offset = 16'(off);
      for (int i = 0; i < tlb_count; i++) begin
        if (tlb_page[i] == pg) begin
          fr      = tlb_frame[i];
          r.hit   = 1'b1;
          r.frame = fr;
          r.phys  = 32'(fr * ps + off);
          if (lru_mode) begin
            for (int j = i + 1; j < tlb_count; j++) begin
              tlb_page[j-1]  = tlb_page[j];
              tlb_frame[j-1] = tlb_frame[j];
            end
            tlb_page[tlb_count-1]  = pg;
            tlb_frame[tlb_count-1] = fr;
          end
          break;
        end
      end
    end else if (req == REQ_FILL) begin
      cap = (tlb_cap == 0) ? 32'd1 : (tlb_cap > DEPTH) ? DEPTH : 32'(tlb_cap);
      if (tlb_count >= cap) begin
        r.evicted      = 1'b1;
        r.evicted_page = tlb_page[0];
        n = tlb_count - int'(cap) + 1;
        for (int i = n; i < tlb_count; i++) begin
          tlb_page[i-n]  = tlb_page[i];
          tlb_frame[i-n] = tlb_frame[i];
        end
        tlb_count -= n;
      end
      if (tlb_count < DEPTH) begin
        tlb_page[tlb_count]  = fpage;
        tlb_frame[tlb_count] = fframe;
        tlb_count++;
      end
    end else if (req == REQ_FLUSH) begin
      tlb_count = 0;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    xlate_res_t e;
    if (result_valid_o) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        e = pending_res.pop_front();
        if (hit_o !== e.hit) report_mismatch("hit", 32'(hit_o), 32'(e.hit));
        if (frame_out_o !== e.frame) report_mismatch("frame", 32'(frame_out_o), 32'(e.frame));
        if (physical_address_o !== e.phys) report_mismatch("phys", physical_address_o, e.phys);
        if (page_number_o !== e.page) report_mismatch("page", page_number_o, e.page);
        if (first_level_index_o !== e.l1_idx)
          report_mismatch("l1_idx", first_level_index_o, e.l1_idx);
        if (second_level_index_o !== e.l2_idx)
          report_mismatch("l2_idx", 32'(second_level_index_o), 32'(e.l2_idx));
        if (page_offset_o !== e.offset)
          report_mismatch("offset", 32'(page_offset_o), 32'(e.offset));
        if (evicted_o !== e.evicted) report_mismatch("evicted", 32'(evicted_o), 32'(e.evicted));
        if (evicted_page_o !== e.evicted_page)
          report_mismatch("evicted_page", evicted_page_o, e.evicted_page);
      end
    end
  end

  // called at a rising edge; start stays high for a back-to-back request
  task automatic send_req(input logic [1:0] req, input logic [31:0] addr,
                          input logic [31:0] fpage, input logic [15:0] fframe);
    int gap;
    start             <= 1'b1;
    req_type_i        <= req;
    logical_address_i <= addr;
    fill_page_i       <= fpage;
    fill_frame_i      <= fframe;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_res.push_back(predict_tlb(req, addr, fpage, fframe));
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_cfg(input logic [1:0] idx, input logic [16:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PAGE_SIZE:   page_size   = val;
      CFG_ENTRIES_TBL: ent_per_tbl = val[10:0];
      CFG_TLB_ENTRIES: tlb_cap     = val[4:0];
      default:         lru_mode    = val[0];
    endcase
  endtask

  task automatic set_cfg(input logic [16:0] ps, input logic [16:0] ept,
                         input logic [16:0] cap, input logic lru);
    drain();
    write_cfg(CFG_PAGE_SIZE, ps);
    write_cfg(CFG_ENTRIES_TBL, ept);
    write_cfg(CFG_TLB_ENTRIES, cap);
    write_cfg(CFG_REPLACE_LRU, {16'd0, lru});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] addr_of(input logic [31:0] pg);
    logic [63:0] ps, a;
    ps = (page_size == 0) ? 64'd1 : (page_size > 17'd65536) ? 64'd65536 : 64'(page_size);
    a  = 64'(pg) * ps + 64'($urandom) % ps;
    return a[31:0];
  endfunction

  // defaults after reset: misses, fills, hits, eviction, flush, undefined code
  task automatic test_defaults;
    send_req(REQ_TRANSLATE, 32'h0, 32'h0, 16'h0);
    send_req(REQ_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 16'h0);
    send_req(REQ_FILL, 32'h0, 32'h0, 16'hFFFF);
    send_req(REQ_FILL, 32'h0, 32'h3FF_FFFF, 16'h1234);
    send_req(REQ_FILL, 32'h0, 32'd5, 16'd7);
    send_req(REQ_FILL, 32'h0, 32'd5, 16'd9);          // duplicate page
    send_req(REQ_TRANSLATE, 32'h0, 32'h0, 16'h0);
    send_req(REQ_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 16'h0);
    send_req(REQ_TRANSLATE, 32'd5 * 64 + 3, 32'h0, 16'h0);
    send_req(REQ_FILL, 32'h0, 32'hFFFF_FFFF, 16'd1);  // evicts oldest
    send_req(REQ_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(REQ_FLUSH, 32'h0, 32'h0, 16'h0);
    send_req(REQ_TRANSLATE, 32'd5 * 64, 32'h0, 16'h0);
  endtask

  // LRU reorder, then capacity lowered below the count
  task automatic test_lru_shrink;
    set_cfg(17'd1, 17'd1, 17'd16, 1'b1);
    for (int i = 0; i < 6; i++) send_req(REQ_FILL, 32'h0, 32'(i + 10), 16'(i + 100));
    send_req(REQ_TRANSLATE, 32'd10, 32'h0, 16'h0);
    send_req(REQ_TRANSLATE, 32'd12, 32'h0, 16'h0);
    set_cfg(17'd1, 17'd1, 17'd2, 1'b1);
    send_req(REQ_TRANSLATE, 32'd15, 32'h0, 16'h0);   // above capacity, still there
    send_req(REQ_FILL, 32'h0, 32'd99, 16'd3);
    send_req(REQ_TRANSLATE, 32'd99, 32'h0, 16'h0);
  endtask

  task automatic test_random_phase(input logic [16:0] ps, input logic [16:0] ept,
                                   input logic [16:0] cap, input logic lru, input int n);
    logic [31:0] max_pg;
    int          sel;
    set_cfg(ps, ept, cap, lru);
    no_gaps = ($urandom_range(0, 3) == 0);
    max_pg  = 32'hFFFF_FFFF / ((ps == 0) ? 32'd1 : (ps > 17'd65536) ? 32'd65536 : 32'(ps));
    // 64-bit modulus: with a page size of one the page range spans all 32 bits
    foreach (page_pool[i])
      page_pool[i] = (i < 4) ? 32'($urandom_range(0, 3))
                             : 32'(64'($urandom) % (64'(max_pg) + 64'd1));
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (k == n / 2) begin
        drain();
        @(posedge clk_i);
      end
      if (sel < 45)
        send_req(REQ_TRANSLATE, addr_of(page_pool[$urandom_range(0, 23)]), $urandom,
                 16'($urandom));
      else if (sel < 55)
        send_req(REQ_TRANSLATE, $urandom, $urandom, 16'($urandom));
      else if (sel < 88)
        send_req(REQ_FILL, $urandom, page_pool[$urandom_range(0, 23)], 16'($urandom));
      else if (sel < 92)
        send_req(REQ_FILL, $urandom, $urandom, 16'($urandom));
      else if (sel < 96)
        send_req(REQ_FLUSH, $urandom, $urandom, 16'($urandom));
      else
        send_req(REQ_UNDEF, $urandom, $urandom, 16'($urandom));
    end
  endtask

  task automatic test_random;
    test_random_phase(17'd0, 17'd0, 17'd0, 1'b0, 100);
    test_random_phase(17'd65536, 17'd1024, 17'd16, 1'b1, 120);
    test_random_phase(17'h1FFFF, 17'h7FF, 17'd31, 1'b0, 100);
    test_random_phase(17'd4096, 17'd512, 17'd8, 1'b1, 150);
    test_random_phase(17'd1, 17'd1, 17'd1, 1'b1, 100);
    test_random_phase(17'd12, 17'd3, 17'd5, 1'b0, 150);
    test_random_phase(17'd64, 17'd4, 17'd4, 1'b1, 150);
    for (int p = 0; p < 4; p++)
      test_random_phase(17'($urandom_range(1, 70000)), 17'($urandom_range(0, 2047)),
                        17'($urandom_range(0, 31)), 1'($urandom), 40);
  endtask

  initial begin
    err_cnt = 0;
    cyc_cnt = 0;
    no_gaps = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_type_i = REQ_TRANSLATE;
    logical_address_i = '0;
    fill_page_i = '0;
    fill_frame_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_PAGE_SIZE;
    cfg_data_i = '0;
    page_size = PAGE_SIZE_RST;
    ent_per_tbl = ENTRIES_TBL_RST;
    tlb_cap = TLB_ENTRIES_RST;
    lru_mode = 1'b0;
    tlb_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_lru_shrink();
    test_random();
    drain();
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("status: pass");
    end else begin
      if (pending_res.size() != 0) $display("%0d results never arrived", pending_res.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tlbflt_pkg.sv
hdl/tlbflt_ctrl.sv
hdl/tlbflt_dp.sv
hdl/tlb_fifo_lru_translate.sv
dv/tlb_fifo_lru_translate_tb.sv
